// ===== rtl/ssl_pkg.sv =====
package ssl_pkg;

    // One list slot: station frequency and its signal level.
    typedef struct packed {
        logic [15:0] freq;
        logic [7:0]  level;
    } slot_t;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_OFFER = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PRIME  = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Insert position reported when an offer is not stored.
    localparam logic [5:0] NOT_STORED = 6'd32;

    // Offer counter saturation value.
    localparam logic [7:0] COUNT_MAX = 8'hFF;

endpackage

// ===== rtl/ssl_slot_ram.sv =====
module ssl_slot_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  ssl_pkg::slot_t  wr_data,
    input  logic [AW-1:0]   rd_addr,
    output ssl_pkg::slot_t  rd_data
);

    ssl_pkg::slot_t mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/sorted_station_list_core.sv =====
// Sorted station list: keeps found stations ordered by signal level, strongest first.
// Input channel s_*: one item per handshake; s_tuser selects clear, offer or read,
// s_tdata carries frequency, level and read index. Output channel m_*: exactly one
// result item per input item, in order.
// From input acceptance to m_tvalid: clear and unused kinds go straight to the
// finish state, a read passes through the prime state, an offer into a list with
// room through the prime state and the insertion walk, and an offer to a full list
// straight to finish. The walk moves one slot per cycle through the slot memory,
// comparing the new level against one stored level per cycle; this walk sets the
// rate, as no new item is taken before an offer's walk is done.
// s_tready is high only while the sequencer is idle; one item is in work at a time.
// A finished result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls longer, the next result waits in the sequencer.
// Reset empties the list at once through the offer count: slots at or beyond the
// valid count read as zero, so no clearing pass over the memory is needed.
module sorted_station_list_core #(
    parameter int DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // station_freq[15:0], signal_level[23:16],
                                   // read_index[28:24], zero pad [31:29]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // insert_position[5:0], entry_freq[21:6],
                                   // entry_level[29:22], offers_seen[37:30],
                                   // list_full[38], zero pad [39]
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = (IW > 6) ? IW : 6;
    localparam int XW = (IW > 5) ? IW : 5;
    localparam int CW = (IW > 8) ? IW : 8;
    localparam logic [8:0] DEPTH_W = 9'(DEPTH);

    ssl_pkg::state_t state_reg, state_next;
    logic [1:0]      act_reg, act_next;
    logic [15:0]     freq_reg, freq_next;
    logic [7:0]      level_reg, level_next;
    logic [4:0]      idx_reg, idx_next;
    logic [IW-1:0]   ptr_reg, ptr_next;
    logic [5:0]      pos_reg, pos_next;
    logic [7:0]      count_reg, count_next;
    logic            out_valid_reg, out_valid_next;
    logic [39:0]     out_data_reg, out_data_next;

    logic            s_acc;
    logic            can_store;
    logic            shift_go;
    logic            read_hit;
    logic            list_full;
    logic            out_load;
    logic [XW-1:0]   idx_ext;
    logic [CW-1:0]   cnt_ext;
    logic [PW-1:0]   ptr_ext;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [IW-1:0]   rd_addr;
    ssl_pkg::slot_t  wr_data;
    ssl_pkg::slot_t  rd_data;
    ssl_pkg::slot_t  entry;

    assign s_tready = (state_reg == ssl_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Width adapters for indexes and positions.
    assign idx_ext = XW'(idx_reg);
    assign cnt_ext = CW'(count_reg);
    assign ptr_ext = PW'(ptr_reg);

    // An offer is stored only while the list has room and the counter is not saturated.
    assign can_store = ({1'b0, count_reg} < DEPTH_W) && (count_reg != ssl_pkg::COUNT_MAX);
    assign list_full = ({1'b0, count_reg} >= DEPTH_W);

    // Shared compare: move the stored entry down while it is weaker than the new one.
    assign shift_go = (ptr_reg != '0) && (rd_data.level < level_reg);

    // Memory write happens only during the insertion walk.
    assign wr_en   = (state_reg == ssl_pkg::ST_SHIFT);
    assign wr_addr = ptr_reg;
    assign wr_data = shift_go ? rd_data : ssl_pkg::slot_t'({freq_reg, level_reg});

    // Read address: slot above the walk pointer, fetched ahead; else the read index.
    always_comb
    begin
        case (state_reg)
            ssl_pkg::ST_PRIME:
            begin
                if (act_reg == ssl_pkg::ACT_OFFER)
                begin
                    rd_addr = ptr_reg - IW'(1);
                end
                else
                begin
                    rd_addr = idx_ext[IW-1:0];
                end
            end
            ssl_pkg::ST_SHIFT:
            begin
                rd_addr = ptr_reg - IW'(2);
            end
            default:
            begin
                rd_addr = idx_ext[IW-1:0];
            end
        endcase
    end

    ssl_slot_ram #(
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A read returns a slot only inside the valid part of the list.
    assign read_hit = (act_reg == ssl_pkg::ACT_READ)
                   && ({4'b0, idx_reg} < {1'b0, count_reg})
                   && ({4'b0, idx_reg} < DEPTH_W);
    assign entry    = read_hit ? rd_data : '0;

    assign out_load = (state_reg == ssl_pkg::ST_FINISH) && (!out_valid_reg || m_tready);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        freq_next      = freq_reg;
        level_next     = level_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ssl_pkg::ST_IDLE:
            begin
                if (s_acc)
                begin
                    act_next   = s_tuser;
                    freq_next  = s_tdata[15:0];
                    level_next = s_tdata[23:16];
                    idx_next   = s_tdata[28:24];
                    pos_next   = ssl_pkg::NOT_STORED;
                    case (s_tuser)
                        ssl_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ssl_pkg::ST_FINISH;
                        end
                        ssl_pkg::ACT_OFFER:
                        begin
                            if (count_reg != ssl_pkg::COUNT_MAX)
                            begin
                                count_next = count_reg + 8'd1;
                            end
                            if (can_store)
                            begin
                                ptr_next   = cnt_ext[IW-1:0];
                                state_next = ssl_pkg::ST_PRIME;
                            end
                            else
                            begin
                                state_next = ssl_pkg::ST_FINISH;
                            end
                        end
                        ssl_pkg::ACT_READ:
                        begin
                            state_next = ssl_pkg::ST_PRIME;
                        end
                        default:
                        begin
                            state_next = ssl_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            ssl_pkg::ST_PRIME:
            begin
                if (act_reg == ssl_pkg::ACT_OFFER)
                begin
                    state_next = ssl_pkg::ST_SHIFT;
                end
                else
                begin
                    state_next = ssl_pkg::ST_FINISH;
                end
            end
            ssl_pkg::ST_SHIFT:
            begin
                if (shift_go)
                begin
                    ptr_next = ptr_reg - IW'(1);
                end
                else
                begin
                    pos_next   = ptr_ext[5:0];
                    state_next = ssl_pkg::ST_FINISH;
                end
            end
            ssl_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, list_full, count_reg, entry.level,
                                      entry.freq, pos_reg};
                    state_next     = ssl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssl_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item payload and walk registers.
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        freq_reg     <= freq_next;
        level_reg    <= level_next;
        idx_reg      <= idx_next;
        ptr_reg      <= ptr_next;
        pos_reg      <= pos_next;
        out_data_reg <= out_data_next;
    end

    // The offer counter only drops when a clear item was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < $past(count_reg)) |->
            ($past(s_acc) && ($past(s_tuser) == ssl_pkg::ACT_CLEAR)))
    else $error("offer counter dropped without a clear item");

    // A new result appears only out of the finishing state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ssl_pkg::ST_FINISH))
    else $error("result raised outside the finishing state");

    // The insertion walk ends only in the finishing state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssl_pkg::ST_SHIFT) |=>
            ((state_reg == ssl_pkg::ST_SHIFT) || (state_reg == ssl_pkg::ST_FINISH)))
    else $error("insertion walk left to an unexpected state");

    // The walk pointer stays inside the list while the walk runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssl_pkg::ST_SHIFT) |-> ({1'b0, cnt_ext} > CW'(ptr_reg)))
    else $error("walk pointer beyond the counted entries");

endmodule

// ===== verif/sorted_station_list_core_tb.sv =====
module sorted_station_list_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = 32;
    localparam int TARGET_ITEMS = 650;
    localparam int DRAIN_CYCLES = 48;
    localparam int MAX_REPORTS = 100;

    // The fourth item kind is not decoded by the block and must leave it untouched.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  action;
        logic [15:0] freq;
        logic [7:0]  level;
        logic [4:0]  idx;
        bit          hold;    // wait for every outstanding result before sending
    } station_item_t;

    typedef struct {
        logic [5:0]  insert_pos;
        logic [15:0] freq;
        logic [7:0]  level;
        logic [7:0]  offers;
        logic        full;
    } station_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // station_freq[15:0], signal_level[23:16], read_index[28:24]
    logic [1:0]  s_tuser = '0;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // insert_position[5:0], entry_freq[21:6], entry_level[29:22],
                                 // offers_seen[37:30], list_full[38]

    station_item_t   pending_items[$];
    station_result_t expected_results[$];
    int              total_items = 1;
    int              items_sent;
    int              results_done;
    int              error_count;
    int              offers_planned;

    // Predicted contents of the station list.
    logic [15:0] list_freq[LIST_DEPTH];
    logic [7:0]  list_level[LIST_DEPTH];
    logic [7:0]  offer_tally;

    sorted_station_list_core #(.DEPTH(LIST_DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Works out the result of one item and updates the predicted list.
    function automatic station_result_t predict_station(logic [1:0] act, logic [15:0] freq,
                                                        logic [7:0] level, logic [4:0] idx);
        station_result_t r;
        int              n;
        int              pos;
        r.insert_pos = ssl_pkg::NOT_STORED;
        r.freq = '0;
        r.level = '0;
        case (act)
            ssl_pkg::ACT_CLEAR:
            begin
                for (int k = 0; k < LIST_DEPTH; k++)
                begin
                    list_freq[k] = '0;
                    list_level[k] = '0;
                end
                offer_tally = '0;
            end
            ssl_pkg::ACT_OFFER:
            begin
                if (offer_tally < LIST_DEPTH && offer_tally != ssl_pkg::COUNT_MAX)
                begin
                    // Stations of equal or higher level stay ahead of the new one.
                    n = int'(offer_tally);
                    pos = 0;
                    while (pos < n && list_level[pos] >= level)
                        pos++;
                    for (int k = n; k > pos; k--)
                    begin
                        list_freq[k] = list_freq[k - 1];
                        list_level[k] = list_level[k - 1];
                    end
                    list_freq[pos] = freq;
                    list_level[pos] = level;
                    r.insert_pos = pos[5:0];
                end
                if (offer_tally != ssl_pkg::COUNT_MAX)
                    offer_tally++;
            end
            ssl_pkg::ACT_READ:
            begin
                if (idx < LIST_DEPTH)
                begin
                    r.freq = list_freq[idx];
                    r.level = list_level[idx];
                end
            end
            default:
            begin
            end
        endcase
        r.offers = offer_tally;
        r.full = (offer_tally >= LIST_DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        error_count++;
        // Keep the log short when a misalignment makes every later result wrong.
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_field(string what, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    function automatic station_item_t make_item(logic [1:0] act, logic [15:0] freq,
                                                logic [7:0] level, logic [4:0] idx, bit hold);
        station_item_t it;
        it.action = act;
        it.freq = freq;
        it.level = level;
        it.idx = idx;
        it.hold = hold;
        return it;
    endfunction

    // Random content; levels lean toward both ends so that ties are common.
    function automatic station_item_t random_item(logic [1:0] act);
        station_item_t it;
        int            valid_now;
        it = make_item(act, 16'($urandom), 8'($urandom), 5'($urandom),
                       ($urandom_range(39) == 0));
        case ($urandom_range(2))
            0: it.level = 8'($urandom_range(0, 3));
            1: it.level = 8'($urandom_range(252, 255));
            default: it.level = 8'($urandom);
        endcase
        valid_now = (offers_planned < LIST_DEPTH) ? offers_planned : LIST_DEPTH;
        if (act == ssl_pkg::ACT_READ && valid_now > 0 && $urandom_range(9) < 7)
            it.idx = 5'($urandom_range(0, valid_now - 1));
        return it;
    endfunction

    // Queues an item and tracks roughly how full the list will be when it arrives.
    task automatic queue_item(station_item_t it);
        pending_items.push_back(it);
        if (it.action == ssl_pkg::ACT_CLEAR)
            offers_planned = 0;
        else if (it.action == ssl_pkg::ACT_OFFER && offers_planned < 255)
            offers_planned++;
    endtask

    // Idle percentages for the three parts of the run.
    function automatic int sender_idle_pct();
        case (items_sent * 3 / total_items)
            0: return 37;
            1: return 81;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (items_sent * 3 / total_items)
            0: return 81;
            1: return 37;
            default: return 0;
        endcase
    endfunction

    // Input side: present queued items, holding each until it is taken.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        station_item_t nxt;
        int            taken_now;
        bit            send;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            items_sent <= 0;
        end
        else
        begin
            taken_now = items_sent + ((s_tvalid && s_tready) ? 1 : 0);
            items_sent <= taken_now;
            if (!s_tvalid || s_tready)
            begin
                send = 1'b0;
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                    send = !pending_items[0].hold || results_done == taken_now;
                if (send)
                begin
                    nxt = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {3'b000, nxt.idx, nxt.level, nxt.freq};
                    s_tuser <= nxt.action;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Both channels: predict on every accepted item, check every accepted result.
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        station_result_t got;
        station_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            results_done <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_station(s_tuser, s_tdata[15:0],
                                                           s_tdata[23:16], s_tdata[28:24]));
            if (m_tvalid && m_tready)
            begin
                results_done <= results_done + 1;
                got.insert_pos = m_tdata[5:0];
                got.freq = m_tdata[21:6];
                got.level = m_tdata[29:22];
                got.offers = m_tdata[37:30];
                got.full = m_tdata[38];
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", m_tdata[31:0], 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("insert_position", 32'(got.insert_pos),
                                32'(want.insert_pos));
                    check_field("entry_freq", 32'(got.freq), 32'(want.freq));
                    check_field("entry_level", 32'(got.level), 32'(want.level));
                    check_field("offers_seen", 32'(got.offers), 32'(want.offers));
                    check_field("list_full", 32'(got.full), 32'(want.full));
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    initial
    begin : run_test
        int seq_count;
        int offers_left;
        int reads_left;
        int r;
        logic [1:0] act;

        for (int k = 0; k < LIST_DEPTH; k++)
        begin
            list_freq[k] = '0;
            list_level[k] = '0;
        end
        offer_tally = '0;

        // Directed part: empty list, unused kind, zero and full levels, ties, clear.
        queue_item(make_item(ssl_pkg::ACT_READ, 16'hFFFF, 8'hFF, 5'd0, 1'b0));
        queue_item(make_item(ACT_UNUSED, 16'hFFFF, 8'hFF, 5'd31, 1'b0));
        queue_item(make_item(ssl_pkg::ACT_CLEAR, 16'hFFFF, 8'hFF, 5'd31, 1'b0));
        queue_item(make_item(ssl_pkg::ACT_OFFER, 16'hFFFF, 8'd0, 5'd31, 1'b0));
        queue_item(make_item(ssl_pkg::ACT_OFFER, 16'h0000, 8'd255, 5'd0, 1'b0));
        queue_item(make_item(ssl_pkg::ACT_OFFER, 16'h1234, 8'd0, 5'd0, 1'b0));
        queue_item(make_item(ssl_pkg::ACT_OFFER, 16'h0001, 8'd255, 5'd0, 1'b0));
        queue_item(make_item(ssl_pkg::ACT_OFFER, 16'h8000, 8'd128, 5'd0, 1'b0));
        for (int k = 0; k < 5; k++)
            queue_item(make_item(ssl_pkg::ACT_READ, 16'h0000, 8'h00, k[4:0], 1'b0));
        queue_item(make_item(ssl_pkg::ACT_READ, 16'hA5A5, 8'h5A, 5'd31, 1'b0));
        queue_item(make_item(ACT_UNUSED, 16'h5555, 8'hAA, 5'd10, 1'b1));
        queue_item(make_item(ssl_pkg::ACT_READ, 16'h0000, 8'h00, 5'd1, 1'b0));
        queue_item(make_item(ssl_pkg::ACT_CLEAR, 16'h0000, 8'h00, 5'd0, 1'b0));
        queue_item(make_item(ssl_pkg::ACT_READ, 16'h0000, 8'h00, 5'd0, 1'b0));

        // Random part: runs of mixed items, most opening with a clear; one run of offers and
        // reads after a clear drives the offer counter into saturation.
        seq_count = 0;
        while (pending_items.size() < TARGET_ITEMS)
        begin
            if (seq_count == 3)
            begin
                queue_item(make_item(ssl_pkg::ACT_CLEAR, 16'($urandom), 8'($urandom),
                                     5'($urandom), 1'b1));
                offers_left = 258;
                reads_left = 24;
                while (offers_left + reads_left > 0)
                begin
                    if ($urandom_range(offers_left + reads_left - 1) < offers_left)
                    begin
                        queue_item(random_item(ssl_pkg::ACT_OFFER));
                        offers_left--;
                    end
                    else
                    begin
                        queue_item(random_item(ssl_pkg::ACT_READ));
                        reads_left--;
                    end
                end
            end
            else
            begin
                if ($urandom_range(4) != 0)
                    queue_item(random_item(ssl_pkg::ACT_CLEAR));
                repeat ($urandom_range(1, 45))
                begin
                    r = $urandom_range(99);
                    if (r < 62)
                        act = ssl_pkg::ACT_OFFER;
                    else if (r < 88)
                        act = ssl_pkg::ACT_READ;
                    else if (r < 94)
                        act = ACT_UNUSED;
                    else
                        act = ssl_pkg::ACT_CLEAR;
                    queue_item(random_item(act));
                end
            end
            seq_count++;
        end
        total_items = pending_items.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every item to be taken and every result to arrive.
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results still expected at the end", 0, expected_results.size());

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
